// ===== sv/rste_pkg.sv =====
// ----------------------------------------------------------------------------
// rste_pkg: shared types and constants of the term evaluator
// Table sizes, request and table codes, result kinds and sequencer states.
// ----------------------------------------------------------------------------
package rste_pkg;

	localparam int MAX_PREPARE = 64;
	localparam int MAX_MAIN    = 256;
	localparam int MAX_STATIC  = 64;
	localparam int MAX_DYNAMIC = 64;

	localparam int WORD_W  = 64;
	localparam int VEC_W   = 256;
	localparam int ROW_W   = 512;
	localparam int LANES   = 8;
	localparam int CNT_W   = 9;
	localparam int CLEAR_ROWS = 256;

	localparam logic [2:0] REQ_WRITE  = 3'd0;
	localparam logic [2:0] REQ_SET    = 3'd1;
	localparam logic [2:0] REQ_CLR    = 3'd2;
	localparam logic [2:0] REQ_MERGE  = 3'd3;
	localparam logic [2:0] REQ_RECALC = 3'd4;

	localparam logic [2:0] SEL_PREPARE = 3'd0;
	localparam logic [2:0] SEL_MAIN    = 3'd1;
	localparam logic [2:0] SEL_STATIC  = 3'd2;
	localparam logic [2:0] SEL_DYNAMIC = 3'd3;
	localparam logic [2:0] SEL_BASE    = 3'd4;

	localparam logic [1:0] KIND_ACK  = 2'd0;
	localparam logic [1:0] KIND_MAIN = 2'd1;
	localparam logic [1:0] KIND_SENS = 2'd2;

	localparam logic [7:0] CFG_PREPARE = 8'd0;
	localparam logic [7:0] CFG_MAIN    = 8'd1;
	localparam logic [7:0] CFG_STATIC  = 8'd2;
	localparam logic [7:0] CFG_DYNAMIC = 8'd3;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CLEAR,
		ST_PREP,
		ST_MAIN,
		ST_STAT,
		ST_DYN,
		ST_EMIT
	} state_t;

	function automatic logic [CNT_W-1:0] clamp_count(input logic [CNT_W-1:0] c,
		input logic [CNT_W-1:0] cap);
		return (c > cap) ? cap : c;
	endfunction

endpackage

// ===== sv/rste_ram.sv =====
// ----------------------------------------------------------------------------
// rste_ram: term table memory
// One row per term holds the condition mask and the result vector as eight
// 64-bit lanes with lane write enables and a registered read port.
// ----------------------------------------------------------------------------
module rste_ram #(
	parameter int DEPTH = 64
) (
	input  logic                        clk,
	input  logic                        we,
	input  logic [$clog2(DEPTH)-1:0]    waddr,
	input  logic [rste_pkg::LANES-1:0]  wmask,
	input  logic [rste_pkg::WORD_W-1:0] wdata,
	input  logic                        re,
	input  logic [$clog2(DEPTH)-1:0]    raddr,
	output logic [rste_pkg::ROW_W-1:0]  rdata
);
	logic [rste_pkg::ROW_W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			for (int l = 0; l < rste_pkg::LANES; l++) begin
				if (wmask[l]) begin
					mem[waddr][l*rste_pkg::WORD_W +: rste_pkg::WORD_W] <= wdata;
				end
			end
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== sv/rste_match.sv =====
// ----------------------------------------------------------------------------
// rste_match: product term match and accumulate unit
// A term matches when every condition bit is set in the vector; its result
// vector is then ORed into the accumulator.
// ----------------------------------------------------------------------------
module rste_match (
	input  logic                        en,
	input  logic [rste_pkg::VEC_W-1:0]  vec,
	input  logic [rste_pkg::ROW_W-1:0]  row,
	input  logic [rste_pkg::VEC_W-1:0]  acc,
	output logic [rste_pkg::VEC_W-1:0]  acc_nx
);
	logic [rste_pkg::VEC_W-1:0] cond;
	logic [rste_pkg::VEC_W-1:0] res;
	logic                       hit;

	assign cond   = row[rste_pkg::VEC_W-1:0];
	assign res    = row[rste_pkg::ROW_W-1:rste_pkg::VEC_W];
	assign hit    = en && ((cond & ~vec) == '0);
	assign acc_nx = hit ? (acc | res) : acc;

endmodule

// ===== sv/relay_scheme_term_evaluator_top.sv =====
// ----------------------------------------------------------------------------
// relay_scheme_term_evaluator_top: sum-of-products relay term evaluator
// Holds the contact status, four term tables and the sensitive base, and
// walks the tables with one shared match unit on a recalculate request.
// ----------------------------------------------------------------------------
// A request is taken at a clock edge where start is high and busy is low.
// Table writes, bit set or clear, status merges and unknown request codes
// give one acknowledge beat on the cycle after they are taken.
// A recalculate walks the prepare, main, static and dynamic tables, one term
// per cycle through a single match unit with a registered table read. Each
// table is walked over its clamped count n of terms, and the walk moves on
// to the next table once the last term read has been matched. The eight
// result beats then come on consecutive cycles, registered from the emit
// state: four main words and four sensitive words, the last one marked by
// last and shown in the cycle where busy falls.
// Each result beat is shown for one cycle with result_valid high; the
// receiver cannot stall, so nothing is ever held back.
// After reset a clearing pass over 256 rows zeroes the tables; busy is high
// meanwhile. Count registers are written on the configuration channel, which
// is always ready, and must be written only while the block is idle.
// ----------------------------------------------------------------------------
module relay_scheme_term_evaluator_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [2:0]  req_type,
	input  logic [2:0]  table_sel,
	input  logic [7:0]  entry_index,
	input  logic [1:0]  word_index,
	input  logic        part_sel,
	input  logic [63:0] data_word,
	input  logic [63:0] keep_word,
	input  logic [7:0]  bit_index,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [7:0]  cfg_index,
	input  logic [15:0] cfg_data,
	output logic        result_valid,
	output logic [1:0]  result_kind,
	output logic [1:0]  out_word_index,
	output logic [63:0] result_word,
	output logic        pending,
	output logic        last
);
	localparam int CW = rste_pkg::CNT_W;
	localparam int PAW = $clog2(rste_pkg::MAX_PREPARE);
	localparam int MAW = $clog2(rste_pkg::MAX_MAIN);
	localparam int SAW = $clog2(rste_pkg::MAX_STATIC);
	localparam int DAW = $clog2(rste_pkg::MAX_DYNAMIC);

	rste_pkg::state_t state_q, state_nx;

	logic [CW-1:0]  cnt_q;
	logic           rd_s1;
	logic [255:0]   status_q, aug_q, main_q, acc_q, base_q;
	logic           pending_q;
	logic [6:0]     prep_cnt_q, stat_cnt_q, dyn_cnt_q;
	logic [8:0]     main_cnt_q;

	logic           result_valid_q, last_q, pend_out_q;
	logic [1:0]     kind_q, oidx_q;
	logic [63:0]    word_q;

	logic [CW-1:0]  np, nm, ns, nd, n_cur;
	logic           accept, phase, issue, phase_done;
	logic [255:0]   stat_nx, vec, acc_nx;
	logic [511:0]   rdata, rd_prep, rd_main, rd_stat, rd_dyn;

	logic           clearing, wr_any, ent_ok_p, ent_ok_m, ent_ok_s, ent_ok_d;
	logic           we_p, we_m, we_s, we_d;
	logic [7:0]     wmask;
	logic [63:0]    wdata;
	logic [7:0]     waddr;

	assign np = rste_pkg::clamp_count({2'b0, prep_cnt_q}, CW'(rste_pkg::MAX_PREPARE));
	assign nm = rste_pkg::clamp_count(main_cnt_q, CW'(rste_pkg::MAX_MAIN));
	assign ns = rste_pkg::clamp_count({2'b0, stat_cnt_q}, CW'(rste_pkg::MAX_STATIC));
	assign nd = rste_pkg::clamp_count({2'b0, dyn_cnt_q}, CW'(rste_pkg::MAX_DYNAMIC));

	assign accept    = start && !busy;
	assign cfg_ready = 1'b1;

	always_comb begin
		busy  = (state_q != rste_pkg::ST_IDLE);
		phase = 1'b0;
		n_cur = '0;
		rdata = rd_prep;
		unique case (state_q)
			rste_pkg::ST_PREP: begin
				phase = 1'b1;
				n_cur = np;
				rdata = rd_prep;
			end
			rste_pkg::ST_MAIN: begin
				phase = 1'b1;
				n_cur = nm;
				rdata = rd_main;
			end
			rste_pkg::ST_STAT: begin
				phase = 1'b1;
				n_cur = ns;
				rdata = rd_stat;
			end
			rste_pkg::ST_DYN: begin
				phase = 1'b1;
				n_cur = nd;
				rdata = rd_dyn;
			end
			default: begin
				phase = 1'b0;
			end
		endcase
		issue      = phase && (cnt_q < n_cur);
		phase_done = phase && !issue && !rd_s1;
	end

	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			rste_pkg::ST_IDLE: begin
				if (accept && req_type == rste_pkg::REQ_RECALC) begin
					state_nx = rste_pkg::ST_PREP;
				end
			end
			rste_pkg::ST_CLEAR: begin
				if (cnt_q == CW'(rste_pkg::CLEAR_ROWS - 1)) begin
					state_nx = rste_pkg::ST_IDLE;
				end
			end
			rste_pkg::ST_PREP: begin
				if (phase_done) state_nx = rste_pkg::ST_MAIN;
			end
			rste_pkg::ST_MAIN: begin
				if (phase_done) state_nx = rste_pkg::ST_STAT;
			end
			rste_pkg::ST_STAT: begin
				if (phase_done) state_nx = rste_pkg::ST_DYN;
			end
			rste_pkg::ST_DYN: begin
				if (phase_done) state_nx = rste_pkg::ST_EMIT;
			end
			rste_pkg::ST_EMIT: begin
				if (cnt_q[2:0] == 3'd7) state_nx = rste_pkg::ST_IDLE;
			end
			default: begin
				state_nx = rste_pkg::ST_IDLE;
			end
		endcase
	end

	always_comb begin
		stat_nx = status_q;
		unique case (req_type)
			rste_pkg::REQ_SET: begin
				stat_nx[bit_index] = 1'b1;
			end
			rste_pkg::REQ_CLR: begin
				stat_nx[bit_index] = 1'b0;
			end
			rste_pkg::REQ_MERGE: begin
				stat_nx[{word_index, 6'd0} +: 64] =
					data_word | (status_q[{word_index, 6'd0} +: 64] & keep_word);
			end
			default: begin
				stat_nx = status_q;
			end
		endcase
	end

	assign vec = (state_q == rste_pkg::ST_PREP) ? status_q : aug_q;

	rste_match u_match (
		.en     (rd_s1),
		.vec    (vec),
		.row    (rdata),
		.acc    (acc_q),
		.acc_nx (acc_nx)
	);

	assign clearing = (state_q == rste_pkg::ST_CLEAR);
	assign wr_any   = accept && (req_type == rste_pkg::REQ_WRITE);
	assign ent_ok_p = ({1'b0, entry_index} < np);
	assign ent_ok_m = ({1'b0, entry_index} < nm);
	assign ent_ok_s = ({1'b0, entry_index} < ns);
	assign ent_ok_d = ({1'b0, entry_index} < nd);

	assign we_p = clearing ? (cnt_q < CW'(rste_pkg::MAX_PREPARE))
		: (wr_any && table_sel == rste_pkg::SEL_PREPARE && ent_ok_p);
	assign we_m = clearing ? (cnt_q < CW'(rste_pkg::MAX_MAIN))
		: (wr_any && table_sel == rste_pkg::SEL_MAIN && ent_ok_m);
	assign we_s = clearing ? (cnt_q < CW'(rste_pkg::MAX_STATIC))
		: (wr_any && table_sel == rste_pkg::SEL_STATIC && ent_ok_s);
	assign we_d = clearing ? (cnt_q < CW'(rste_pkg::MAX_DYNAMIC))
		: (wr_any && table_sel == rste_pkg::SEL_DYNAMIC && ent_ok_d);

	assign wmask = clearing ? 8'hFF : (8'd1 << {part_sel, word_index});
	assign wdata = clearing ? 64'd0 : data_word;
	assign waddr = clearing ? cnt_q[7:0] : entry_index;

	rste_ram #(.DEPTH(rste_pkg::MAX_PREPARE)) u_prep (
		.clk   (clk),
		.we    (we_p),
		.waddr (waddr[PAW-1:0]),
		.wmask (wmask),
		.wdata (wdata),
		.re    (issue && state_q == rste_pkg::ST_PREP),
		.raddr (cnt_q[PAW-1:0]),
		.rdata (rd_prep)
	);

	rste_ram #(.DEPTH(rste_pkg::MAX_MAIN)) u_main (
		.clk   (clk),
		.we    (we_m),
		.waddr (waddr[MAW-1:0]),
		.wmask (wmask),
		.wdata (wdata),
		.re    (issue && state_q == rste_pkg::ST_MAIN),
		.raddr (cnt_q[MAW-1:0]),
		.rdata (rd_main)
	);

	rste_ram #(.DEPTH(rste_pkg::MAX_STATIC)) u_stat (
		.clk   (clk),
		.we    (we_s),
		.waddr (waddr[SAW-1:0]),
		.wmask (wmask),
		.wdata (wdata),
		.re    (issue && state_q == rste_pkg::ST_STAT),
		.raddr (cnt_q[SAW-1:0]),
		.rdata (rd_stat)
	);

	rste_ram #(.DEPTH(rste_pkg::MAX_DYNAMIC)) u_dyn (
		.clk   (clk),
		.we    (we_d),
		.waddr (waddr[DAW-1:0]),
		.wmask (wmask),
		.wdata (wdata),
		.re    (issue && state_q == rste_pkg::ST_DYN),
		.raddr (cnt_q[DAW-1:0]),
		.rdata (rd_dyn)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= rste_pkg::ST_CLEAR;
			cnt_q          <= '0;
			rd_s1          <= 1'b0;
			status_q       <= '0;
			base_q         <= '0;
			pending_q      <= 1'b0;
			prep_cnt_q     <= '0;
			main_cnt_q     <= '0;
			stat_cnt_q     <= '0;
			dyn_cnt_q      <= '0;
			result_valid_q <= 1'b0;
		end else begin
			state_q        <= state_nx;
			rd_s1          <= issue;
			result_valid_q <= (accept && req_type != rste_pkg::REQ_RECALC)
				|| (state_q == rste_pkg::ST_EMIT);

			if (cfg_valid && cfg_ready) begin
				unique case (cfg_index)
					rste_pkg::CFG_PREPARE: prep_cnt_q <= cfg_data[6:0];
					rste_pkg::CFG_MAIN:    main_cnt_q <= cfg_data[8:0];
					rste_pkg::CFG_STATIC:  stat_cnt_q <= cfg_data[6:0];
					rste_pkg::CFG_DYNAMIC: dyn_cnt_q  <= cfg_data[6:0];
					default: begin
					end
				endcase
			end

			if (state_q == rste_pkg::ST_EMIT && state_nx == rste_pkg::ST_IDLE) begin
				cnt_q <= '0;
			end else if (clearing || state_q == rste_pkg::ST_EMIT) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (phase_done || accept) begin
				cnt_q <= '0;
			end else if (issue) begin
				cnt_q <= cnt_q + 1'b1;
			end

			if (accept) begin
				if (req_type == rste_pkg::REQ_RECALC) begin
					pending_q <= 1'b0;
				end else begin
					status_q <= stat_nx;
					if (stat_nx != status_q) begin
						pending_q <= 1'b1;
					end
					if (wr_any && table_sel == rste_pkg::SEL_BASE) begin
						base_q[{word_index, 6'd0} +: 64] <= data_word;
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			acc_q      <= '0;
			kind_q     <= rste_pkg::KIND_ACK;
			oidx_q     <= 2'd0;
			word_q     <= 64'd0;
			pend_out_q <= (req_type == rste_pkg::REQ_RECALC) ? 1'b0
				: (pending_q || (stat_nx != status_q));
			last_q     <= 1'b1;
		end else if (phase_done) begin
			unique case (state_q)
				rste_pkg::ST_PREP: begin
					aug_q <= status_q | acc_q;
					acc_q <= '0;
				end
				rste_pkg::ST_MAIN: begin
					main_q <= acc_q;
					acc_q  <= base_q;
				end
				default: begin
					acc_q <= acc_q;
				end
			endcase
		end else if (rd_s1) begin
			acc_q <= acc_nx;
		end

		if (state_q == rste_pkg::ST_EMIT) begin
			kind_q     <= cnt_q[2] ? rste_pkg::KIND_SENS : rste_pkg::KIND_MAIN;
			oidx_q     <= cnt_q[1:0];
			word_q     <= cnt_q[2] ? acc_q[{cnt_q[1:0], 6'd0} +: 64]
				: main_q[{cnt_q[1:0], 6'd0} +: 64];
			pend_out_q <= 1'b0;
			last_q     <= (cnt_q[2:0] == 3'd7);
		end
	end

	assign result_valid   = result_valid_q;
	assign result_kind    = kind_q;
	assign out_word_index = oidx_q;
	assign result_word    = word_q;
	assign pending        = pend_out_q;
	assign last           = last_q;

endmodule

// ===== tb/rste_checker.sv =====
// ----------------------------------------------------------------------------
// rste_checker: result predictor and scoreboard for the relay term evaluator
// Watches accepted requests and count writes, keeps its own copy of the
// status, term tables and counts, predicts every result beat and compares
// each beat that the block shows against the oldest prediction.
// ----------------------------------------------------------------------------
module rste_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic        busy,
	input  logic [2:0]  req_type,
	input  logic [2:0]  table_sel,
	input  logic [7:0]  entry_index,
	input  logic [1:0]  word_index,
	input  logic        part_sel,
	input  logic [63:0] data_word,
	input  logic [63:0] keep_word,
	input  logic [7:0]  bit_index,
	input  logic        cfg_valid,
	input  logic        cfg_ready,
	input  logic [7:0]  cfg_index,
	input  logic [15:0] cfg_data,
	input  logic        result_valid,
	input  logic [1:0]  result_kind,
	input  logic [1:0]  out_word_index,
	input  logic [63:0] result_word,
	input  logic        pending,
	input  logic        last,
	output int          fail_count,
	output int          beats_waiting
);

	typedef struct packed {
		logic [1:0]  kind;
		logic [1:0]  widx;
		logic [63:0] word;
		logic        pend;
		logic        last;
	} beat_t;

	beat_t expected_beats[$];

	logic [rste_pkg::VEC_W-1:0] status_vec;
	logic [rste_pkg::VEC_W-1:0] sens_base;
	logic                       pend_flag;
	logic [rste_pkg::VEC_W-1:0] prep_cond [rste_pkg::MAX_PREPARE];
	logic [rste_pkg::VEC_W-1:0] prep_res  [rste_pkg::MAX_PREPARE];
	logic [rste_pkg::VEC_W-1:0] main_cond [rste_pkg::MAX_MAIN];
	logic [rste_pkg::VEC_W-1:0] main_res  [rste_pkg::MAX_MAIN];
	logic [rste_pkg::VEC_W-1:0] stat_cond [rste_pkg::MAX_STATIC];
	logic [rste_pkg::VEC_W-1:0] stat_res  [rste_pkg::MAX_STATIC];
	logic [rste_pkg::VEC_W-1:0] dyn_cond  [rste_pkg::MAX_DYNAMIC];
	logic [rste_pkg::VEC_W-1:0] dyn_res   [rste_pkg::MAX_DYNAMIC];
	int                         n_prep, n_main, n_stat, n_dyn;

	assign beats_waiting = expected_beats.size();

	function automatic int limit_to(input int c, input int cap);
		return (c > cap) ? cap : c;
	endfunction

	task automatic report(input string what);
		$display("MISMATCH at %0t: %s", $realtime, what);
		fail_count++;
	endtask

	task automatic push_beat(input logic [1:0] k, input logic [1:0] w,
		input logic [63:0] d, input logic p, input logic l);
		beat_t b;
		b.kind = k;
		b.widx = w;
		b.word = d;
		b.pend = p;
		b.last = l;
		expected_beats = {expected_beats, b};
	endtask

	task automatic apply_request();
		logic [rste_pkg::VEC_W-1:0] before_vec;
		logic [rste_pkg::VEC_W-1:0] aug;
		logic [rste_pkg::VEC_W-1:0] main_acc;
		logic [rste_pkg::VEC_W-1:0] sens_acc;
		logic [63:0]                old_word;
		int                         e;
		e = int'(entry_index);
		before_vec = status_vec;
		case (req_type)
			rste_pkg::REQ_WRITE: begin
				case (table_sel)
					rste_pkg::SEL_PREPARE:
					if (e < limit_to(n_prep, rste_pkg::MAX_PREPARE)) begin
						if (part_sel) prep_res[e][64*word_index +: 64] = data_word;
						else prep_cond[e][64*word_index +: 64] = data_word;
					end
					rste_pkg::SEL_MAIN:
					if (e < limit_to(n_main, rste_pkg::MAX_MAIN)) begin
						if (part_sel) main_res[e][64*word_index +: 64] = data_word;
						else main_cond[e][64*word_index +: 64] = data_word;
					end
					rste_pkg::SEL_STATIC:
					if (e < limit_to(n_stat, rste_pkg::MAX_STATIC)) begin
						if (part_sel) stat_res[e][64*word_index +: 64] = data_word;
						else stat_cond[e][64*word_index +: 64] = data_word;
					end
					rste_pkg::SEL_DYNAMIC:
					if (e < limit_to(n_dyn, rste_pkg::MAX_DYNAMIC)) begin
						if (part_sel) dyn_res[e][64*word_index +: 64] = data_word;
						else dyn_cond[e][64*word_index +: 64] = data_word;
					end
					rste_pkg::SEL_BASE: sens_base[64*word_index +: 64] = data_word;
					default: ;
				endcase
			end
			rste_pkg::REQ_SET: status_vec[bit_index] = 1'b1;
			rste_pkg::REQ_CLR: status_vec[bit_index] = 1'b0;
			rste_pkg::REQ_MERGE: begin
				old_word = status_vec[64*word_index +: 64];
				status_vec[64*word_index +: 64] = data_word | (old_word & keep_word);
			end
			rste_pkg::REQ_RECALC: begin
				aug = status_vec;
				for (int t = 0; t < limit_to(n_prep, rste_pkg::MAX_PREPARE); t++)
					if ((prep_cond[t] & ~status_vec) == '0) aug |= prep_res[t];
				main_acc = '0;
				for (int t = 0; t < limit_to(n_main, rste_pkg::MAX_MAIN); t++)
					if ((main_cond[t] & ~aug) == '0) main_acc |= main_res[t];
				sens_acc = sens_base;
				for (int t = 0; t < limit_to(n_stat, rste_pkg::MAX_STATIC); t++)
					if ((stat_cond[t] & ~aug) == '0) sens_acc |= stat_res[t];
				for (int t = 0; t < limit_to(n_dyn, rste_pkg::MAX_DYNAMIC); t++)
					if ((dyn_cond[t] & ~aug) == '0) sens_acc |= dyn_res[t];
				pend_flag = 1'b0;
				for (int w = 0; w < 4; w++)
					push_beat(rste_pkg::KIND_MAIN, w[1:0], main_acc[64*w +: 64],
						1'b0, 1'b0);
				for (int w = 0; w < 4; w++)
					push_beat(rste_pkg::KIND_SENS, w[1:0], sens_acc[64*w +: 64],
						1'b0, w == 3);
			end
			default: ;
		endcase
		if (req_type != rste_pkg::REQ_RECALC) begin
			if (status_vec != before_vec) pend_flag = 1'b1;
			push_beat(rste_pkg::KIND_ACK, 2'd0, 64'd0, pend_flag, 1'b1);
		end
	endtask

	initial begin
		fail_count = 0;
		status_vec = '0;
		sens_base = '0;
		pend_flag = 1'b0;
		n_prep = 0;
		n_main = 0;
		n_stat = 0;
		n_dyn = 0;
		for (int i = 0; i < rste_pkg::MAX_PREPARE; i++) begin
			prep_cond[i] = '0;
			prep_res[i] = '0;
		end
		for (int i = 0; i < rste_pkg::MAX_MAIN; i++) begin
			main_cond[i] = '0;
			main_res[i] = '0;
		end
		for (int i = 0; i < rste_pkg::MAX_STATIC; i++) begin
			stat_cond[i] = '0;
			stat_res[i] = '0;
		end
		for (int i = 0; i < rste_pkg::MAX_DYNAMIC; i++) begin
			dyn_cond[i] = '0;
			dyn_res[i] = '0;
		end
	end

	always @(posedge clk) begin
		beat_t exp_b;
		if (arst_n) begin
			if (result_valid) begin
				if (expected_beats.size() == 0) begin
					report($sformatf("unexpected beat kind %0d word %0d",
						result_kind, out_word_index));
				end else begin
					exp_b = expected_beats.pop_front();
					if (result_kind !== exp_b.kind)
						report($sformatf("result_kind %0d, expected %0d",
							result_kind, exp_b.kind));
					if (out_word_index !== exp_b.widx)
						report($sformatf("out_word_index %0d, expected %0d",
							out_word_index, exp_b.widx));
					if (result_word !== exp_b.word)
						report($sformatf("result_word %h, expected %h",
							result_word, exp_b.word));
					if (pending !== exp_b.pend)
						report($sformatf("pending %b, expected %b", pending, exp_b.pend));
					if (last !== exp_b.last)
						report($sformatf("last %b, expected %b", last, exp_b.last));
				end
			end
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					rste_pkg::CFG_PREPARE: n_prep = int'(cfg_data[6:0]);
					rste_pkg::CFG_MAIN:    n_main = int'(cfg_data[8:0]);
					rste_pkg::CFG_STATIC:  n_stat = int'(cfg_data[6:0]);
					rste_pkg::CFG_DYNAMIC: n_dyn  = int'(cfg_data[6:0]);
					default: ;
				endcase
			end
			if (start && !busy) apply_request();
		end
	end

endmodule

// ===== tb/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench: stimulus and verdict for the relay term evaluator
// Drives directed and random requests in bursts with random gaps, changes
// the term counts between phases while the block is idle, and leaves all
// prediction and comparison to the checker.
// ----------------------------------------------------------------------------
module testbench;

	logic        clk;
	logic        arst_n;
	logic        start;
	logic        busy;
	logic [2:0]  req_type;
	logic [2:0]  table_sel;
	logic [7:0]  entry_index;
	logic [1:0]  word_index;
	logic        part_sel;
	logic [63:0] data_word;
	logic [63:0] keep_word;
	logic [7:0]  bit_index;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [7:0]  cfg_index;
	logic [15:0] cfg_data;
	logic        result_valid;
	logic [1:0]  result_kind;
	logic [1:0]  out_word_index;
	logic [63:0] result_word;
	logic        pending;
	logic        last;
	int          fail_count;
	int          beats_waiting;
	int          burst_left;
	int          cnt_prep, cnt_main, cnt_stat, cnt_dyn;

	relay_scheme_term_evaluator_top DUT (.*);

	rste_checker u_checker (.*);

	initial clk = 1'b0;
	always #10 clk = ~clk;

	function automatic logic [63:0] rand64();
		return {$urandom, $urandom};
	endfunction

	function automatic logic [63:0] sparse64();
		if ($urandom_range(0, 2) == 0) return 64'd0;
		return rand64() & rand64() & rand64() & rand64();
	endfunction

	task automatic send_req(input logic [2:0] rq, input logic [2:0] sel,
		input logic [7:0] ent, input logic [1:0] wi, input logic ps,
		input logic [63:0] d, input logic [63:0] k, input logic [7:0] b);
		start       <= 1'b1;
		req_type    <= rq;
		table_sel   <= sel;
		entry_index <= ent;
		word_index  <= wi;
		part_sel    <= ps;
		data_word   <= d;
		keep_word   <= k;
		bit_index   <= b;
		do @(posedge clk); while (busy);
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			start <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
			burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(10, 30)
				: $urandom_range(0, 4);
		end
	endtask

	task automatic settle();
		start <= 1'b0;
		@(posedge clk);
		while (beats_waiting != 0 || busy) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_count(input logic [7:0] idx, input logic [15:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic set_counts(input int p, input int m, input int s, input int d);
		settle();
		write_count(rste_pkg::CFG_PREPARE, p[15:0]);
		write_count(rste_pkg::CFG_MAIN, m[15:0]);
		write_count(rste_pkg::CFG_STATIC, s[15:0]);
		write_count(rste_pkg::CFG_DYNAMIC, d[15:0]);
		cnt_prep = int'(p[6:0]);
		cnt_main = int'(m[8:0]);
		cnt_stat = int'(s[6:0]);
		cnt_dyn  = int'(d[6:0]);
	endtask

	task automatic rand_entry(input int n, output logic [7:0] ent);
		if (n == 0 || $urandom_range(0, 9) == 0) ent = 8'($urandom_range(0, 255));
		else ent = 8'($urandom_range(0, (n > 256 ? 256 : n) - 1));
	endtask

	task automatic rand_item();
		int          pick;
		logic [2:0]  sel;
		logic [2:0]  any_sel;
		logic [7:0]  ent;
		logic [7:0]  any_ent;
		logic [1:0]  wi;
		logic        ps;
		logic [7:0]  b;
		logic [2:0]  bad_req;
		int          n;
		pick = $urandom_range(0, 99);
		sel = 3'($urandom_range(0, 4));
		if ($urandom_range(0, 19) == 0) sel = 3'($urandom_range(0, 7));
		any_sel = 3'($urandom_range(0, 7));
		any_ent = 8'($urandom_range(0, 255));
		wi = 2'($urandom_range(0, 3));
		ps = 1'($urandom_range(0, 1));
		b = 8'($urandom_range(0, 255));
		bad_req = 3'($urandom_range(5, 7));
		case (sel)
			rste_pkg::SEL_PREPARE: n = cnt_prep;
			rste_pkg::SEL_MAIN:    n = cnt_main;
			rste_pkg::SEL_STATIC:  n = cnt_stat;
			rste_pkg::SEL_DYNAMIC: n = cnt_dyn;
			default:               n = 0;
		endcase
		rand_entry(n, ent);
		if (pick < 45)
			send_req(rste_pkg::REQ_WRITE, sel, ent, wi, ps,
				($urandom_range(0, 1) ? sparse64() : rand64()), rand64(), b);
		else if (pick < 65)
			send_req($urandom_range(0, 1) ? rste_pkg::REQ_SET : rste_pkg::REQ_CLR,
				any_sel, any_ent, wi, ps, rand64(), rand64(), b);
		else if (pick < 78)
			send_req(rste_pkg::REQ_MERGE, any_sel, any_ent, wi, ps, rand64(),
				($urandom_range(0, 1) ? ~sparse64() : rand64()), b);
		else if (pick < 95)
			send_req(rste_pkg::REQ_RECALC, any_sel, any_ent, wi, ps, rand64(), rand64(), b);
		else
			send_req(bad_req, any_sel, any_ent, wi, ps, rand64(), rand64(), b);
	endtask

	initial begin
		#(20 * 2000000);
		$display("Test completed with failures");
		$finish;
	end

	initial begin
		arst_n      = 1'b0;
		start       = 1'b0;
		req_type    = '0;
		table_sel   = '0;
		entry_index = '0;
		word_index  = '0;
		part_sel    = 1'b0;
		data_word   = '0;
		keep_word   = '0;
		bit_index   = '0;
		cfg_valid   = 1'b0;
		cfg_index   = '0;
		cfg_data    = '0;
		burst_left  = 0;
		cnt_prep = 0;
		cnt_main = 0;
		cnt_stat = 0;
		cnt_dyn  = 0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Counts at zero: every term write falls beyond its table.
		send_req(rste_pkg::REQ_WRITE, rste_pkg::SEL_MAIN, 8'd0, 2'd0, 1'b0, '1, '0, 8'd0);
		send_req(rste_pkg::REQ_WRITE, rste_pkg::SEL_BASE, 8'd255, 2'd3, 1'b1,
			64'h8000_0000_0000_0001, '0, 8'd0);
		send_req(rste_pkg::REQ_WRITE, 3'd5, 8'd0, 2'd0, 1'b0, '1, '1, 8'd0);
		send_req(rste_pkg::REQ_WRITE, 3'd7, 8'd0, 2'd1, 1'b1, '1, '1, 8'd0);
		send_req(rste_pkg::REQ_SET, rste_pkg::SEL_PREPARE, 8'd0, 2'd0, 1'b0, '0, '0, 8'd0);
		send_req(rste_pkg::REQ_SET, rste_pkg::SEL_PREPARE, 8'd0, 2'd0, 1'b0, '0, '0, 8'd255);
		send_req(rste_pkg::REQ_SET, rste_pkg::SEL_PREPARE, 8'd0, 2'd0, 1'b0, '0, '0, 8'd255);
		send_req(rste_pkg::REQ_RECALC, rste_pkg::SEL_PREPARE, 8'd0, 2'd0, 1'b0, '0, '0, 8'd0);
		send_req(rste_pkg::REQ_CLR, rste_pkg::SEL_PREPARE, 8'd0, 2'd0, 1'b0, '0, '0, 8'd63);
		send_req(rste_pkg::REQ_CLR, rste_pkg::SEL_PREPARE, 8'd0, 2'd0, 1'b0, '0, '0, 8'd0);
		send_req(rste_pkg::REQ_MERGE, rste_pkg::SEL_PREPARE, 8'd0, 2'd2, 1'b0, '1, '0, 8'd0);
		send_req(rste_pkg::REQ_MERGE, rste_pkg::SEL_PREPARE, 8'd0, 2'd2, 1'b0, '0, '1, 8'd0);
		send_req(rste_pkg::REQ_MERGE, rste_pkg::SEL_PREPARE, 8'd0, 2'd1, 1'b0, '0, '0, 8'd0);
		send_req(3'd5, rste_pkg::SEL_PREPARE, 8'd0, 2'd0, 1'b0, '0, '0, 8'd0);
		send_req(3'd7, 3'd7, 8'd255, 2'd3, 1'b1, '1, '1, 8'd255);
		send_req(rste_pkg::REQ_RECALC, rste_pkg::SEL_PREPARE, 8'd0, 2'd0, 1'b0, '0, '0, 8'd0);

		// A two-level chain: a prepare term feeds a main and a static term.
		set_counts(2, 2, 2, 2);
		write_count(8'd200, 16'hFFFF);
		send_req(rste_pkg::REQ_WRITE, rste_pkg::SEL_PREPARE, 8'd1, 2'd0, 1'b0, 64'h1, '0, 8'd0);
		send_req(rste_pkg::REQ_WRITE, rste_pkg::SEL_PREPARE, 8'd1, 2'd1, 1'b1, 64'h10, '0, 8'd0);
		send_req(rste_pkg::REQ_WRITE, rste_pkg::SEL_MAIN, 8'd1, 2'd1, 1'b0, 64'h10, '0, 8'd0);
		send_req(rste_pkg::REQ_WRITE, rste_pkg::SEL_MAIN, 8'd1, 2'd3, 1'b1, '1, '0, 8'd0);
		send_req(rste_pkg::REQ_WRITE, rste_pkg::SEL_STATIC, 8'd0, 2'd1, 1'b0, 64'h10, '0, 8'd0);
		send_req(rste_pkg::REQ_WRITE, rste_pkg::SEL_DYNAMIC, 8'd1, 2'd0, 1'b1, 64'hF0, '0, 8'd0);
		send_req(rste_pkg::REQ_WRITE, rste_pkg::SEL_STATIC, 8'd2, 2'd0, 1'b1, '1, '0, 8'd0);
		send_req(rste_pkg::REQ_SET, rste_pkg::SEL_PREPARE, 8'd0, 2'd0, 1'b0, '0, '0, 8'd0);
		send_req(rste_pkg::REQ_RECALC, rste_pkg::SEL_PREPARE, 8'd0, 2'd0, 1'b0, '0, '0, 8'd0);

		for (int phase = 0; phase < 9; phase++) begin
			case (phase)
				0: set_counts(4, 8, 4, 4);
				1: set_counts(64, 256, 64, 64);
				2: set_counts(1, 1, 1, 1);
				3: set_counts(127, 511, 127, 127);
				4: set_counts(2, 3, 2, 2);
				5: set_counts($urandom_range(0, 65535), $urandom_range(0, 65535),
					$urandom_range(0, 65535), $urandom_range(0, 65535));
				6: set_counts(0, 0, 0, 0);
				7: set_counts(8, 16, 8, 8);
				default: set_counts($urandom_range(0, 10), $urandom_range(0, 20),
					$urandom_range(0, 10), $urandom_range(0, 10));
			endcase
			repeat ((phase == 1 || phase == 3 || phase == 5) ? 25 : 50) rand_item();
		end

		start <= 1'b0;
		@(posedge clk);
		while (beats_waiting != 0) @(posedge clk);
		repeat (50) @(posedge clk);
		if (fail_count == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
